@@ hdl/gnsf_pkg.sv @@
// gnsf_pkg: shared types, widths, register indexes and constant tables
// for the grid neighbor spin field block and its checker
// depends on nothing
package gnsf_pkg;

  // stream and config port widths
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 24;
  localparam int CFG_ADDR_W  = 2;
  localparam int CFG_DATA_W  = 16;

  // payload field widths
  localparam int ROW_W   = 6;
  localparam int COL_W   = 6;
  localparam int SPINS_W = 32;
  localparam int POS_W   = 5;
  localparam int VAL_W   = 16;

  // config register widths
  localparam int GRID_W = 7;
  localparam int LEN_W  = 6;
  localparam int GAIN_W = 16;

  // register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_ROWS = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_COLS = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_LEN  = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_GAIN = 2'd3;

  // request kinds carried in in_tuser
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  // reset values of the config registers
  localparam logic [GRID_W-1:0] ROWS_RST = 7'd64;
  localparam logic [GRID_W-1:0] COLS_RST = 7'd64;
  localparam logic [LEN_W-1:0]  LEN_RST  = 6'd32;
  localparam logic [GAIN_W-1:0] GAIN_RST = 16'd256;

  // shared multiplier and reciprocal division
  localparam int MUL_A_W     = 19;
  localparam int MUL_B_W     = 23;
  localparam int MUL_P_W     = MUL_A_W + MUL_B_W;
  localparam int RECIP_SHIFT = 24;
  localparam int QUO_W       = MUL_P_W - RECIP_SHIFT;
  localparam int CNT_W       = 4;

  // scaled reciprocal of the full neighbor count, exact for 19-bit dividends
  function automatic logic [MUL_B_W-1:0] recip(input logic [CNT_W-1:0] full);
    logic [MUL_B_W-1:0] m;
    case (full)
      4'd3:    m = 23'd5592406;
      4'd5:    m = 23'd3355444;
      4'd8:    m = 23'd2097152;
      default: m = 23'd0;
    endcase
    return m;
  endfunction

  // row offset of neighbor j, scanned row by row, center skipped
  function automatic logic [1:0] nb_dr(input logic [2:0] j);
    logic [1:0] d;
    case (j)
      3'd0, 3'd1, 3'd2: d = 2'b11;
      3'd3, 3'd4:       d = 2'b00;
      default:          d = 2'b01;
    endcase
    return d;
  endfunction

  // column offset of neighbor j
  function automatic logic [1:0] nb_dc(input logic [2:0] j);
    logic [1:0] d;
    case (j)
      3'd0, 3'd3, 3'd5: d = 2'b11;
      3'd1, 3'd6:       d = 2'b00;
      default:          d = 2'b01;
    endcase
    return d;
  endfunction

endpackage

@@ hdl/gnsf_ram.sv @@
// gnsf_ram: generic simple dual port ram, one write and one registered read
// no dependencies
module gnsf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/grid_neighbor_spin_field.sv @@
// grid_neighbor_spin_field: grid of cells with presence bits and spin strings,
// answers neighbor field queries one string position per result
// depends on gnsf_pkg and gnsf_ram
//
// channel  dir  handshake          payload
// in_      in   tvalid / tready    tuser: req_type
//                                  tdata: row, col, present, spins
// out_     out  tvalid / tready    tuser: cell_absent, tlast: last
//                                  tdata: position, field_value
// cfg_     in   we                 addr: register index, wdata: value
//
// a write transfer leaves the block in S_IDLE, ready for the next transfer; a
// query of an out-of-grid cell goes to S_ABS, of an absent cell via S_CTR; a
// present cell is scanned through the shared read address over eight neighbors, then
// one multiplier is used twice per position (gain times sum, then reciprocal)
// after reset the presence ram is cleared, one cell a cycle, over all
// MAX_ROWS * MAX_COLS cells (4096 by default); in_tready stays low meanwhile
// a result waiting in the output register stalls only the next result, and a
// new transfer is taken while the final result of a query still waits
module grid_neighbor_spin_field
  import gnsf_pkg::*;
#(
  parameter int MAX_ROWS   = 64,
  parameter int MAX_COLS   = 64,
  parameter int MAX_LENGTH = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // row, col, present, spins
  input  logic                   in_tuser,   // req_type
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // position, field_value
  output logic                   out_tuser,  // cell_absent
  output logic                   out_tlast,
  input  logic                   cfg_we,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int CELLS  = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int SPW    = (MAX_LENGTH < SPINS_W) ? MAX_LENGTH : SPINS_W;
  localparam int KW     = (SPW > 1) ? $clog2(SPW) : 1;

  typedef enum logic [8:0] {
    S_CLR   = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_CTR   = 9'b000000100,
    S_SCAN  = 9'b000001000,
    S_DRAIN = 9'b000010000,
    S_MUL   = 9'b000100000,
    S_DIV   = 9'b001000000,
    S_EMIT  = 9'b010000000,
    S_ABS   = 9'b100000000
  } state_t;

  // cell address is row * MAX_COLS + col
  function automatic logic [ADDR_W-1:0] cell_addr(input logic [GRID_W-1:0] r,
                                                  input logic [GRID_W-1:0] c);
    return ADDR_W'(int'(r) * MAX_COLS + int'(c));
  endfunction

  // input unpacking
  logic [ROW_W-1:0] in_row;
  logic [COL_W-1:0] in_col;
  logic             in_present;
  logic [SPW-1:0]   in_spins;
  logic             in_xfer;

  assign in_row     = in_tdata[ROW_W-1:0];
  assign in_col     = in_tdata[ROW_W+COL_W-1:ROW_W];
  assign in_present = in_tdata[ROW_W+COL_W];
  assign in_spins   = in_tdata[ROW_W+COL_W+1 +: SPW];
  assign in_xfer    = in_tvalid && in_tready;

  // config registers
  logic [GRID_W-1:0] rows_r, cols_r;
  logic [LEN_W-1:0]  len_r;
  logic [GAIN_W-1:0] gain_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= ROWS_RST;
      cols_r <= COLS_RST;
      len_r  <= LEN_RST;
      gain_r <= GAIN_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_ROWS: rows_r <= cfg_wdata[GRID_W-1:0];
        REG_COLS: cols_r <= cfg_wdata[GRID_W-1:0];
        REG_LEN:  len_r  <= cfg_wdata[LEN_W-1:0];
        REG_GAIN: gain_r <= cfg_wdata[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // clamped grid size and string length
  logic [GRID_W-1:0] rows_eff, cols_eff;
  logic [LEN_W-1:0]  len_eff;

  always_comb begin
    if (rows_r < 7'd2) begin
      rows_eff = 7'd2;
    end else if (int'(rows_r) > MAX_ROWS) begin
      rows_eff = GRID_W'(MAX_ROWS);
    end else begin
      rows_eff = rows_r;
    end
    if (cols_r < 7'd2) begin
      cols_eff = 7'd2;
    end else if (int'(cols_r) > MAX_COLS) begin
      cols_eff = GRID_W'(MAX_COLS);
    end else begin
      cols_eff = cols_r;
    end
    if (len_r < 6'd1) begin
      len_eff = 6'd1;
    end else if (int'(len_r) > SPW) begin
      len_eff = LEN_W'(SPW);
    end else begin
      len_eff = len_r;
    end
  end

  // sequencer and datapath registers
  state_t             state_r, state_nxt;
  logic [ADDR_W-1:0]  clr_addr_r, clr_addr_nxt;
  logic [ROW_W-1:0]   row_r, row_nxt;
  logic [COL_W-1:0]   col_r, col_nxt;
  logic [2:0]         j_r, j_nxt;
  logic               pend_r, pend_nxt;
  logic [CNT_W-1:0]   full_r, full_nxt;
  logic [CNT_W-1:0]   npres_r, npres_nxt;
  logic [CNT_W-1:0]   cnt_r [SPW];
  logic [CNT_W-1:0]   cnt_nxt [SPW];
  logic [KW-1:0]      k_r, k_nxt;
  logic [MUL_A_W-1:0] prod_r, prod_nxt;
  logic               sign_r, sign_nxt;
  logic [QUO_W-1:0]   quo_r, quo_nxt;

  // output register
  logic               out_valid_r, out_valid_nxt;
  logic [POS_W-1:0]   out_pos_r, out_pos_nxt;
  logic [VAL_W-1:0]   out_val_r, out_val_nxt;
  logic               out_abs_r, out_abs_nxt;
  logic               out_last_r, out_last_nxt;
  logic               out_free;

  // ram ports
  logic              pres_we, pres_wdata, pres_rdata;
  logic              spin_we;
  logic [ADDR_W-1:0] pres_waddr, raddr;
  logic [SPW-1:0]    spin_rdata;

  // addresses of the incoming cell and of the neighbor under scan
  logic              in_inside;
  logic [ADDR_W-1:0] in_addr;
  logic [1:0]        d_r, d_c;
  logic [7:0]        nb_r, nb_c;
  logic              nb_ok;
  logic [ADDR_W-1:0] nb_addr;

  assign in_inside = ({1'b0, in_row} < rows_eff) && ({1'b0, in_col} < cols_eff);
  assign in_addr   = cell_addr({1'b0, in_row}, {1'b0, in_col});

  assign d_r     = nb_dr(j_r);
  assign d_c     = nb_dc(j_r);
  assign nb_r    = {2'b00, row_r} + {{6{d_r[1]}}, d_r};
  assign nb_c    = {2'b00, col_r} + {{6{d_c[1]}}, d_c};
  assign nb_ok   = !nb_r[7] && (nb_r[6:0] < rows_eff) && !nb_c[7] && (nb_c[6:0] < cols_eff);
  assign nb_addr = cell_addr(nb_r[6:0], nb_c[6:0]);

  // both rams are read at the same address: the neighbor under scan, else the incoming cell
  assign raddr = (state_r == S_SCAN) ? nb_addr : in_addr;

  // one multiplier, shared by gain times sum and by the reciprocal divide
  logic [GAIN_W-1:0]  abs_gain;
  logic               gain_neg;
  logic [CNT_W-1:0]   cur_cnt;
  logic [5:0]         sum6, abs_sum6;
  logic               sum_neg;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [MUL_P_W-1:0] mul_p;

  assign gain_neg = gain_r[GAIN_W-1];
  assign abs_gain = gain_neg ? (~gain_r + 16'd1) : gain_r;
  assign cur_cnt  = cnt_r[k_r];
  // sum of +1 / -1 over present neighbors is 2 * ones - present count
  assign sum6     = {1'b0, cur_cnt, 1'b0} - {2'b00, npres_r};
  assign sum_neg  = sum6[5];
  assign abs_sum6 = sum_neg ? (~sum6 + 6'd1) : sum6;

  always_comb begin
    if (state_r == S_DIV) begin
      mul_a = prod_r;
      mul_b = recip(full_r);
    end else begin
      mul_a = MUL_A_W'(abs_gain);
      mul_b = MUL_B_W'(abs_sum6[CNT_W-1:0]);
    end
  end

  assign mul_p = MUL_P_W'(mul_a) * MUL_P_W'(mul_b);

  // signed result with saturation of the single positive overflow
  logic [QUO_W-1:0] neg_quo;
  logic [VAL_W-1:0] field_val;

  assign neg_quo = ~quo_r + 18'd1;

  always_comb begin
    if (sign_r) begin
      field_val = neg_quo[VAL_W-1:0];
    end else if (quo_r > 18'd32767) begin
      field_val = 16'h7fff;
    end else begin
      field_val = quo_r[VAL_W-1:0];
    end
  end

  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt     = state_r;
    clr_addr_nxt  = clr_addr_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    j_nxt         = j_r;
    pend_nxt      = pend_r;
    full_nxt      = full_r;
    npres_nxt     = npres_r;
    cnt_nxt       = cnt_r;
    k_nxt         = k_r;
    prod_nxt      = prod_r;
    sign_nxt      = sign_r;
    quo_nxt       = quo_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_pos_nxt   = out_pos_r;
    out_val_nxt   = out_val_r;
    out_abs_nxt   = out_abs_r;
    out_last_nxt  = out_last_r;
    in_tready     = 1'b0;
    pres_we       = 1'b0;
    pres_waddr    = in_addr;
    pres_wdata    = in_present;
    spin_we       = 1'b0;

    case (state_r)
      S_CLR: begin
        // presence clearing pass after reset
        pres_we      = 1'b1;
        pres_waddr   = clr_addr_r;
        pres_wdata   = 1'b0;
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == ADDR_W'(CELLS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_xfer) begin
          if (in_tuser == REQ_WRITE) begin
            // writes outside the grid are dropped
            pres_we = in_inside;
            spin_we = in_inside;
          end else begin
            row_nxt   = in_row;
            col_nxt   = in_col;
            state_nxt = in_inside ? S_CTR : S_ABS;
          end
        end
      end
      S_CTR: begin
        // presence of the queried cell is back from the ram
        j_nxt     = 3'd0;
        pend_nxt  = 1'b0;
        full_nxt  = '0;
        npres_nxt = '0;
        for (int i = 0; i < SPW; i++) begin
          cnt_nxt[i] = '0;
        end
        state_nxt = pres_rdata ? S_SCAN : S_ABS;
      end
      S_SCAN, S_DRAIN: begin
        // collect the neighbor whose read was issued in the previous cycle
        if (pend_r && pres_rdata) begin
          npres_nxt = npres_r + 1'b1;
          for (int i = 0; i < SPW; i++) begin
            cnt_nxt[i] = cnt_r[i] + CNT_W'(spin_rdata[i]);
          end
        end
        if (state_r == S_SCAN) begin
          // issue the read of neighbor j
          pend_nxt = nb_ok;
          full_nxt = full_r + CNT_W'(nb_ok);
          j_nxt    = j_r + 1'b1;
          if (j_r == 3'd7) begin
            state_nxt = S_DRAIN;
          end
        end else begin
          pend_nxt  = 1'b0;
          k_nxt     = '0;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        prod_nxt  = mul_p[MUL_A_W-1:0];
        sign_nxt  = gain_neg ^ sum_neg;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        quo_nxt   = mul_p[MUL_P_W-1:RECIP_SHIFT];
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_pos_nxt   = POS_W'(k_r);
          out_val_nxt   = field_val;
          out_abs_nxt   = 1'b0;
          out_last_nxt  = (LEN_W'(k_r) == len_eff - 6'd1);
          if (LEN_W'(k_r) == len_eff - 6'd1) begin
            state_nxt = S_IDLE;
          end else begin
            k_nxt     = k_r + 1'b1;
            state_nxt = S_MUL;
          end
        end
      end
      S_ABS: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_pos_nxt   = '0;
          out_val_nxt   = '0;
          out_abs_nxt   = 1'b1;
          out_last_nxt  = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    row_r      <= row_nxt;
    col_r      <= col_nxt;
    j_r        <= j_nxt;
    pend_r     <= pend_nxt;
    full_r     <= full_nxt;
    npres_r    <= npres_nxt;
    cnt_r      <= cnt_nxt;
    k_r        <= k_nxt;
    prod_r     <= prod_nxt;
    sign_r     <= sign_nxt;
    quo_r      <= quo_nxt;
    out_pos_r  <= out_pos_nxt;
    out_val_r  <= out_val_nxt;
    out_abs_r  <= out_abs_nxt;
    out_last_r <= out_last_nxt;
  end

  // presence map, cleared by the pass after reset
  gnsf_ram #(
    .WIDTH (1),
    .DEPTH (CELLS)
  ) u_pres_ram (
    .clk   (clk),
    .we    (pres_we),
    .waddr (pres_waddr),
    .wdata (pres_wdata),
    .raddr (raddr),
    .rdata (pres_rdata)
  );

  // spin strings, valid only once written
  gnsf_ram #(
    .WIDTH (SPW),
    .DEPTH (CELLS)
  ) u_spin_ram (
    .clk   (clk),
    .we    (spin_we),
    .waddr (in_addr),
    .wdata (in_spins),
    .raddr (raddr),
    .rdata (spin_rdata)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W - POS_W - VAL_W){1'b0}}, out_val_r, out_pos_r};
  assign out_tuser  = out_abs_r;
  assign out_tlast  = out_last_r;

endmodule

@@ hdl/gnsf_checker.sv @@
// gnsf_checker: port-level assertions for grid_neighbor_spin_field,
// attached by the bind at the end of this file
// depends on gnsf_pkg
module gnsf_checker
  import gnsf_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   in_tuser,   // req_type
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,  // position, field_value
  input logic                   out_tuser,  // cell_absent
  input logic                   out_tlast
);

  // position expected on the next result of a query
  logic [POS_W-1:0] exp_pos_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_pos_r <= '0;
    end else if (out_tvalid && out_tready) begin
      exp_pos_r <= out_tlast ? '0 : exp_pos_r + 1'b1;
    end
  end

  // a stalled result holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
    $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled result changed");

  // an absent cell answers with one zero result that closes the query
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast && out_tdata == '0 && exp_pos_r == '0)
    else $error("absent result malformed");

  // results of a query count positions up from zero
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[POS_W-1:0] == exp_pos_r)
    else $error("result position out of order");

  // a query is never followed by a transfer in the next cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser == REQ_QUERY |=> !in_tready)
    else $error("input taken during a query");

endmodule

bind grid_neighbor_spin_field gnsf_checker u_gnsf_checker (.*);

@@ test/tb_top.sv @@
// tb_top: self-checking bench for grid_neighbor_spin_field, a directed table then
// random writes and queries, results checked against the table or a local field predictor
// depends on gnsf_pkg and the grid_neighbor_spin_field rtl
`timescale 1ns / 100ps

module tb_top;
  import gnsf_pkg::*;

  localparam int GRID_MAX       = 64;
  localparam int LEN_MAX        = 32;
  localparam int CELL_COUNT     = GRID_MAX * GRID_MAX;
  localparam int SETTLE_CYCLES  = 16;     // margin for a write transfer to settle
  localparam int TAIL_CYCLES    = 200;    // longer than one full-length query
  localparam int WATCHDOG_LIMIT = 20000;  // covers the presence clear after reset
  localparam int SEGMENTS       = 6;
  localparam int SEG_ITEMS      = 68;

  typedef struct {
    logic [POS_W-1:0] position;
    logic [VAL_W-1:0] field_value;
    logic             cell_absent;
    logic             last;
  } field_res_t;

  typedef enum logic [1:0] {CHK_MODEL, CHK_ABSENT, CHK_FLAT} check_t;
  typedef enum logic {STEP_XFER, STEP_REGS} step_kind_t;

  typedef struct {
    step_kind_t         kind;
    logic               req;
    logic [ROW_W-1:0]   row;
    logic [COL_W-1:0]   col;
    logic               present;
    logic [SPINS_W-1:0] spins;
    check_t             chk;
    logic [VAL_W-1:0]   flat_val;
    logic [GRID_W-1:0]  rows_v;
    logic [GRID_W-1:0]  cols_v;
    logic [LEN_W-1:0]   len_v;
    logic [GAIN_W-1:0]  gain_v;
  } step_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   in_tuser = REQ_WRITE;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;
  logic                   out_tlast;
  logic                   cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0]  cfg_addr = REG_ROWS;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

  // predictor copy of the block state and registers
  bit                 cell_live [CELL_COUNT];
  logic [SPINS_W-1:0] cell_spins [CELL_COUNT];
  logic [GRID_W-1:0]  rows_reg = ROWS_RST;
  logic [GRID_W-1:0]  cols_reg = COLS_RST;
  logic [LEN_W-1:0]   len_reg  = LEN_RST;
  logic [GAIN_W-1:0]  gain_reg = GAIN_RST;

  field_res_t  field_q [$];   // field results still owed by the block
  field_res_t  head_res;
  step_t       steps [$];
  int unsigned errors = 0;
  int unsigned quiet_cycles = 0;
  int unsigned snd_idle = 0;  // percent of cycles the sender holds off
  int unsigned rcv_idle = 0;  // percent of cycles the receiver stalls

  grid_neighbor_spin_field dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic int clamp_dim(input int v, input int lo, input int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // append one owed result at the tail of the queue
  task automatic owe_result(input field_res_t res);
    field_q.insert(field_q.size(), res);
  endtask

  // append one row to the stimulus table
  task automatic add_step(input step_t s);
    steps.insert(steps.size(), s);
  endtask

  task automatic push_absent();
    field_res_t res;
    res.position    = '0;
    res.field_value = '0;
    res.cell_absent = 1'b1;
    res.last        = 1'b1;
    owe_result(res);
  endtask

  // same value at every string position, for rows whose answer is obvious
  task automatic push_flat(input logic [VAL_W-1:0] val);
    int len;
    field_res_t res;
    len = clamp_dim(int'(len_reg), 1, LEN_MAX);
    for (int k = 0; k < len; k++) begin
      res.position    = POS_W'(k);
      res.field_value = val;
      res.cell_absent = 1'b0;
      res.last        = (k == len - 1);
      owe_result(res);
    end
  endtask

  task automatic predict_field(input logic [ROW_W-1:0] row, input logic [COL_W-1:0] col);
    int er, ec, len, nr, nc, full, sum;
    int nbrs [$];
    longint quo;
    field_res_t res;
    er  = clamp_dim(int'(rows_reg), 2, GRID_MAX);
    ec  = clamp_dim(int'(cols_reg), 2, GRID_MAX);
    len = clamp_dim(int'(len_reg), 1, LEN_MAX);
    if (int'(row) >= er || int'(col) >= ec || !cell_live[int'(row) * GRID_MAX + int'(col)]) begin
      push_absent();
      return;
    end
    // full count takes every in-grid neighbor, the sum only the occupied ones
    full = 0;
    for (int dr = -1; dr <= 1; dr++) begin
      for (int dc = -1; dc <= 1; dc++) begin
        nr = int'(row) + dr;
        nc = int'(col) + dc;
        if ((dr != 0 || dc != 0) && nr >= 0 && nc >= 0 && nr < er && nc < ec) begin
          full++;
          if (cell_live[nr * GRID_MAX + nc]) nbrs.insert(nbrs.size(), nr * GRID_MAX + nc);
        end
      end
    end
    for (int k = 0; k < len; k++) begin
      sum = 0;
      foreach (nbrs[j]) sum += cell_spins[nbrs[j]][k] ? 1 : -1;
      // signed division truncates toward zero
      quo = (longint'($signed(gain_reg)) * longint'(sum)) / longint'(full);
      if (quo > 32767) quo = 32767;
      if (quo < -32768) quo = -32768;
      res.position    = POS_W'(k);
      res.field_value = quo[VAL_W-1:0];
      res.cell_absent = 1'b0;
      res.last        = (k == len - 1);
      owe_result(res);
    end
  endtask

  // update the predictor for one accepted transfer
  task automatic account_req(input logic req, input logic [ROW_W-1:0] row,
                             input logic [COL_W-1:0] col, input logic present,
                             input logic [SPINS_W-1:0] spins);
    int er, ec;
    er = clamp_dim(int'(rows_reg), 2, GRID_MAX);
    ec = clamp_dim(int'(cols_reg), 2, GRID_MAX);
    if (req == REQ_QUERY) begin
      predict_field(row, col);
    end else if (int'(row) < er && int'(col) < ec) begin
      // spins are kept even for an absent cell, writes outside the grid drop
      cell_live[int'(row) * GRID_MAX + int'(col)]  = present;
      cell_spins[int'(row) * GRID_MAX + int'(col)] = spins;
    end
  endtask

  // ---------------------------------------------------------------- drivers

  task automatic send_req(input logic req, input logic [ROW_W-1:0] row,
                          input logic [COL_W-1:0] col, input logic present,
                          input logic [SPINS_W-1:0] spins);
    while ($urandom_range(0, 99) < snd_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= {3'b000, spins, present, col, row};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // hold the sender off until every owed result transfer has come back
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (field_q.size() != 0) @(posedge clk);
  endtask

  task automatic reg_write(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  // registers change only with the block idle
  task automatic write_regs(input logic [GRID_W-1:0] r, input logic [GRID_W-1:0] c,
                            input logic [LEN_W-1:0] l, input logic [GAIN_W-1:0] g);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    reg_write(REG_ROWS, CFG_DATA_W'(r));
    reg_write(REG_COLS, CFG_DATA_W'(c));
    reg_write(REG_LEN, CFG_DATA_W'(l));
    reg_write(REG_GAIN, g);
    cfg_we   <= 1'b0;
    rows_reg = r;
    cols_reg = c;
    len_reg  = l;
    gain_reg = g;
  endtask

  function automatic step_t xfer(input logic req, input int row, input int col,
                                 input logic present, input logic [SPINS_W-1:0] spins,
                                 input check_t chk, input logic [VAL_W-1:0] flat_val);
    step_t s;
    s.kind     = STEP_XFER;
    s.req      = req;
    s.row      = ROW_W'(row);
    s.col      = COL_W'(col);
    s.present  = present;
    s.spins    = spins;
    s.chk      = chk;
    s.flat_val = flat_val;
    s.rows_v   = '0;
    s.cols_v   = '0;
    s.len_v    = '0;
    s.gain_v   = '0;
    return s;
  endfunction

  function automatic step_t regs(input int r, input int c, input int l,
                                 input logic [GAIN_W-1:0] g);
    step_t s;
    s.kind     = STEP_REGS;
    s.req      = REQ_WRITE;
    s.row      = '0;
    s.col      = '0;
    s.present  = 1'b0;
    s.spins    = '0;
    s.chk      = CHK_MODEL;
    s.flat_val = '0;
    s.rows_v   = GRID_W'(r);
    s.cols_v   = GRID_W'(c);
    s.len_v    = LEN_W'(l);
    s.gain_v   = g;
    return s;
  endfunction

  // random register settings, mostly small grids and short strings
  function automatic logic [GRID_W-1:0] pick_dim();
    case ($urandom_range(0, 9))
      0:       return GRID_W'($urandom_range(0, 1));     // clamps up to 2
      1:       return GRID_W'($urandom_range(65, 127));  // clamps down to 64
      2, 3:    return GRID_W'($urandom_range(9, 64));
      default: return GRID_W'($urandom_range(2, 8));
    endcase
  endfunction

  function automatic logic [LEN_W-1:0] pick_len();
    case ($urandom_range(0, 9))
      0:       return '0;                                // clamps up to 1
      1:       return LEN_W'($urandom_range(33, 63));    // clamps down to 32
      2, 3:    return LEN_W'($urandom_range(9, 32));
      default: return LEN_W'($urandom_range(1, 8));
    endcase
  endfunction

  function automatic logic [GAIN_W-1:0] pick_gain();
    case ($urandom_range(0, 9))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return GAIN_RST;
      3:       return '0;
      default: return GAIN_W'($urandom);
    endcase
  endfunction

  // ---------------------------------------------------------------- checking

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (field_q.size() == 0) begin
        $error("result transfer with nothing expected: position %0d value %h absent %b",
               out_tdata[POS_W-1:0], out_tdata[POS_W +: VAL_W], out_tuser);
        errors++;
      end else begin
        head_res = field_q.pop_front();
        if (out_tdata[POS_W-1:0] !== head_res.position) begin
          $error("position: expected %0d, got %0d", head_res.position, out_tdata[POS_W-1:0]);
          errors++;
        end
        if (out_tdata[POS_W +: VAL_W] !== head_res.field_value) begin
          $error("field_value: expected %h, got %h", head_res.field_value,
                 out_tdata[POS_W +: VAL_W]);
          errors++;
        end
        if (out_tuser !== head_res.cell_absent) begin
          $error("cell_absent: expected %b, got %b", head_res.cell_absent, out_tuser);
          errors++;
        end
        if (out_tlast !== head_res.last) begin
          $error("last: expected %b, got %b", head_res.last, out_tlast);
          errors++;
        end
      end
    end
    out_tready <= ($urandom_range(0, 99) >= rcv_idle);
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("tb_top NOT OK");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- stimulus

  initial begin
    int er, ec, base_r, base_c, span_r, span_c;
    logic               req, present;
    logic [ROW_W-1:0]   row;
    logic [COL_W-1:0]   col;
    logic [SPINS_W-1:0] spins;

    // reset register values first: 64 x 64 grid, 32 positions, gain 1.0
    add_step(xfer(REQ_QUERY, 0, 0, 1'b0, '0, CHK_ABSENT, '0));
    add_step(xfer(REQ_QUERY, 63, 63, 1'b0, '0, CHK_ABSENT, '0));
    add_step(xfer(REQ_WRITE, 0, 1, 1'b1, 32'hFFFF_FFFF, CHK_MODEL, '0));
    add_step(xfer(REQ_WRITE, 1, 0, 1'b1, 32'hFFFF_FFFF, CHK_MODEL, '0));
    add_step(xfer(REQ_WRITE, 1, 1, 1'b1, 32'hFFFF_FFFF, CHK_MODEL, '0));
    add_step(xfer(REQ_WRITE, 0, 0, 1'b1, 32'h0000_0000, CHK_MODEL, '0));
    add_step(xfer(REQ_QUERY, 0, 0, 1'b0, '0, CHK_FLAT, 16'h0100));  // corner, all up
    add_step(xfer(REQ_WRITE, 63, 63, 1'b1, 32'hFFFF_FFFF, CHK_MODEL, '0));
    add_step(xfer(REQ_WRITE, 62, 62, 1'b1, 32'h0000_0000, CHK_MODEL, '0));
    add_step(xfer(REQ_QUERY, 63, 63, 1'b0, '0, CHK_MODEL, '0));
    add_step(xfer(REQ_WRITE, 32, 31, 1'b1, 32'hA5A5_0FF0, CHK_MODEL, '0));
    add_step(xfer(REQ_WRITE, 31, 31, 1'b1, 32'h1234_5678, CHK_MODEL, '0));
    add_step(xfer(REQ_QUERY, 31, 31, 1'b0, '0, CHK_MODEL, '0));   // interior, eight
    add_step(xfer(REQ_WRITE, 5, 5, 1'b0, 32'hFFFF_FFFF, CHK_MODEL, '0));
    add_step(xfer(REQ_QUERY, 5, 5, 1'b0, '0, CHK_ABSENT, '0));   // written as absent
    // most negative gain, length beyond range clamps to 32
    add_step(regs(64, 64, 63, 16'h8000));
    add_step(xfer(REQ_QUERY, 0, 0, 1'b0, '0, CHK_FLAT, 16'h8000));
    add_step(xfer(REQ_WRITE, 0, 1, 1'b1, 32'h0000_0000, CHK_MODEL, '0));
    add_step(xfer(REQ_WRITE, 1, 0, 1'b1, 32'h0000_0000, CHK_MODEL, '0));
    add_step(xfer(REQ_WRITE, 1, 1, 1'b1, 32'h0000_0000, CHK_MODEL, '0));
    add_step(xfer(REQ_QUERY, 0, 0, 1'b0, '0, CHK_FLAT, 16'h7FFF));  // overflow saturates
    // rows below range clamp to 2, columns above to 64, length 0 clamps to 1
    add_step(regs(0, 127, 0, 16'h7FFF));
    add_step(xfer(REQ_QUERY, 2, 0, 1'b0, '0, CHK_ABSENT, '0));   // outside the grid
    add_step(xfer(REQ_WRITE, 5, 3, 1'b1, 32'hFFFF_FFFF, CHK_MODEL, '0));  // dropped
    add_step(xfer(REQ_QUERY, 5, 3, 1'b0, '0, CHK_ABSENT, '0));
    add_step(xfer(REQ_QUERY, 1, 1, 1'b0, '0, CHK_MODEL, '0));    // border of five
    // tiny gain: -3/5 truncates toward zero
    add_step(regs(127, 0, 1, 16'h0001));
    add_step(xfer(REQ_QUERY, 1, 1, 1'b0, '0, CHK_FLAT, 16'h0000));

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    snd_idle = 38;
    rcv_idle = 84;
    foreach (steps[i]) begin
      if (steps[i].kind == STEP_REGS) begin
        write_regs(steps[i].rows_v, steps[i].cols_v, steps[i].len_v, steps[i].gain_v);
      end else begin
        send_req(steps[i].req, steps[i].row, steps[i].col, steps[i].present, steps[i].spins);
        case (steps[i].chk)
          CHK_ABSENT: push_absent();
          CHK_FLAT:   push_flat(steps[i].flat_val);
          default:    account_req(steps[i].req, steps[i].row, steps[i].col,
                                  steps[i].present, steps[i].spins);
        endcase
      end
    end

    // random segments: receiver slow then sender slow, then both at full rate
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      snd_idle = (seg < 2) ? 38 : (seg < 4) ? 84 : 0;
      rcv_idle = (seg < 2) ? 84 : (seg < 4) ? 38 : 0;
      write_regs(pick_dim(), pick_dim(), pick_len(), pick_gain());
      er = clamp_dim(int'(rows_reg), 2, GRID_MAX);
      ec = clamp_dim(int'(cols_reg), 2, GRID_MAX);
      // addresses cluster in a small window so neighbors fill in, corners favored
      if (er <= 6) begin
        base_r = 0;
        span_r = er;
      end else begin
        case ($urandom_range(0, 2))
          0:       base_r = 0;
          1:       base_r = er - 6;
          default: base_r = $urandom_range(0, er - 6);
        endcase
        span_r = 6;
      end
      if (ec <= 6) begin
        base_c = 0;
        span_c = ec;
      end else begin
        case ($urandom_range(0, 2))
          0:       base_c = 0;
          1:       base_c = ec - 6;
          default: base_c = $urandom_range(0, ec - 6);
        endcase
        span_c = 6;
      end
      for (int n = 0; n < SEG_ITEMS; n++) begin
        if ($urandom_range(0, 49) == 0) wait_drained();
        req = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 9) == 0) begin
          row = ROW_W'($urandom);
          col = COL_W'($urandom);
        end else begin
          row = ROW_W'(base_r + $urandom_range(0, span_r));
          col = COL_W'(base_c + $urandom_range(0, span_c));
        end
        present = ($urandom_range(0, 99) < 85);
        case ($urandom_range(0, 4))
          0:       spins = '0;
          1:       spins = '1;
          default: spins = $urandom;
        endcase
        send_req(req, row, col, present, spins);
        account_req(req, row, col, present, spins);
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0 && field_q.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hdl/gnsf_pkg.sv
hdl/gnsf_ram.sv
hdl/grid_neighbor_spin_field.sv
hdl/gnsf_checker.sv
test/tb_top.sv
